// File: src/bscu_pkg.sv
`timescale 1ns / 1ps
// Package for the bitmask stream compaction unit.
// Shared constants, the queue status struct and the lane-count clamp; no dependencies.
package bscu_pkg;

    localparam int MAX_LANES   = 8;   // mask bits and value ports that exist
    localparam int LANES_DEF   = 8;
    localparam int VAL_W       = 32;
    localparam int MASK_W      = 8;
    localparam int QUEUE_DEPTH = 2;

    // status the queue reports to both of its neighbors
    typedef struct packed {
        logic can_push;
        logic has_item;
    } t_q_status;

    // lanes actually examined: LANES clamped to 1 .. MAX_LANES
    function automatic int f_eff_lanes(input int lanes);
        int n;
        n = lanes;
        if (n > MAX_LANES) begin
            n = MAX_LANES;
        end
        if (n < 1) begin
            n = 1;
        end
        return n;
    endfunction

endpackage

// File: src/bscu_queue.sv
`timescale 1ns / 1ps
// Small register FIFO between the front and back halves of the compaction unit.
// Depends on bscu_pkg for the status struct.
module bscu_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [W-1:0]          i_push_data,
    input  logic                  i_pop,
    output logic [W-1:0]          o_head,
    output bscu_pkg::t_q_status   o_stat
);
    import bscu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        if (p == AW'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + AW'(1);
        end
        return q;
    endfunction

    assign o_stat.can_push = (r_count != CW'(DEPTH));
    assign o_stat.has_item = (r_count != '0);
    assign o_head          = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? f_wrap(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? f_wrap(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: src/bscu_front.sv
`timescale 1ns / 1ps
// Front half: accepts input beats, trims the mask to the examined lanes and
// drops empty groups. Depends on bscu_pkg.
module bscu_front #(
    parameter int LANES = bscu_pkg::LANES_DEF,
    parameter int EW    = 8
) (
    input  logic                                                i_valid,
    output logic                                                o_ready,
    input  logic [bscu_pkg::MASK_W-1:0]                         i_select_mask,
    input  logic [bscu_pkg::MAX_LANES-1:0][bscu_pkg::VAL_W-1:0] i_lanes,
    input  logic                                                i_last_group,
    input  bscu_pkg::t_q_status                                 i_stat,
    output logic                                                o_push,
    output logic [EW-1:0]                                       o_push_data
);
    import bscu_pkg::*;

    localparam int EFF = f_eff_lanes(LANES);

    logic [EFF-1:0] eff_mask;

    assign eff_mask    = i_select_mask[EFF-1:0];
    assign o_ready     = i_stat.can_push;
    // a group with no kept lane is consumed here and never queued
    assign o_push      = i_valid && i_stat.can_push && (|eff_mask);
    assign o_push_data = {i_last_group, i_lanes[EFF-1:0], eff_mask};

endmodule

// File: src/bscu_back.sv
`timescale 1ns / 1ps
// Back half: walks the queued mask one set bit per cycle while i_ready does not stall the
// output, and drives the registered output beat. Depends on bscu_pkg.
module bscu_back #(
    parameter int LANES = bscu_pkg::LANES_DEF,
    parameter int EW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [EW-1:0]                 i_head,
    input  bscu_pkg::t_q_status           i_stat,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bscu_pkg::VAL_W-1:0]    o_kept_value,
    output logic                          o_item_done,
    output logic                          o_batch_done
);
    import bscu_pkg::*;

    localparam int EFF = f_eff_lanes(LANES);
    localparam int IW  = (EFF > 1) ? $clog2(EFF) : 1;

    logic                          r_busy, n_busy;
    logic [EFF-1:0]                r_mask, n_mask;
    logic [EFF-1:0][VAL_W-1:0]     r_vals, n_vals;
    logic                          r_last, n_last;
    logic                          r_out_valid, n_out_valid;
    logic [VAL_W-1:0]              r_kept, n_kept;
    logic                          r_item_done, n_item_done;
    logic                          r_batch_done, n_batch_done;

    logic [EFF-1:0]            head_mask;
    logic [EFF-1:0][VAL_W-1:0] head_vals;
    logic                      head_last;
    logic [IW-1:0]             pick;
    logic [EFF-1:0]            rem;
    logic                      out_adv, step, finishing, load;

    assign head_mask = i_head[EFF-1:0];
    assign head_vals = i_head[EFF +: EFF*VAL_W];
    assign head_last = i_head[EW-1];

    // lowest set bit of the remaining mask
    always_comb begin
        pick = '0;
        for (int j = EFF - 1; j >= 0; j--) begin
            if (r_mask[j]) begin
                pick = IW'(j);
            end
        end
    end

    assign rem       = r_mask & (r_mask - EFF'(1));
    assign out_adv   = !r_out_valid || i_ready;
    assign step      = r_busy && out_adv;
    assign finishing = step && (rem == '0);
    assign load      = i_stat.has_item && (!r_busy || finishing);
    assign o_pop     = load;

    always_comb begin
        n_busy = r_busy;
        n_mask = r_mask;
        n_vals = r_vals;
        n_last = r_last;
        if (load) begin
            n_busy = 1'b1;
            n_mask = head_mask;
            n_vals = head_vals;
            n_last = head_last;
        end else if (finishing) begin
            n_busy = 1'b0;
        end else if (step) begin
            n_mask = rem;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_kept       = r_kept;
        n_item_done  = r_item_done;
        n_batch_done = r_batch_done;
        if (step) begin
            n_out_valid  = 1'b1;
            n_kept       = r_vals[pick];
            n_item_done  = (rem == '0);
            n_batch_done = (rem == '0) && r_last;
        end else if (i_ready) begin
            n_out_valid  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask       <= n_mask;
        r_vals       <= n_vals;
        r_last       <= n_last;
        r_kept       <= n_kept;
        r_item_done  <= n_item_done;
        r_batch_done <= n_batch_done;
    end

    assign o_valid      = r_out_valid;
    assign o_kept_value = r_kept;
    assign o_item_done  = r_item_done;
    assign o_batch_done = r_batch_done;

endmodule

// File: src/bitmask_stream_compaction_unit.sv
`timescale 1ns / 1ps
// Bitmask stream compaction unit: top level. Uses bscu_pkg, bscu_front, bscu_queue, bscu_back.
// The first kept value of a group passes the queue, the back-end mask register and the output register.
// Throughput: one output beat per cycle while i_ready does not stall it; a group emits one value per set
// bit of its trimmed mask, walked one bit per beat. Empty groups never reach the back end.
// Reset (synchronous, active low) empties the queue and the output register; no clearing pass.
module bitmask_stream_compaction_unit #(
    parameter int LANES = bscu_pkg::LANES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bscu_pkg::MASK_W-1:0]   i_select_mask,
    input  logic [bscu_pkg::VAL_W-1:0]    i_lane_value_0,
    input  logic [bscu_pkg::VAL_W-1:0]    i_lane_value_1,
    input  logic [bscu_pkg::VAL_W-1:0]    i_lane_value_2,
    input  logic [bscu_pkg::VAL_W-1:0]    i_lane_value_3,
    input  logic [bscu_pkg::VAL_W-1:0]    i_lane_value_4,
    input  logic [bscu_pkg::VAL_W-1:0]    i_lane_value_5,
    input  logic [bscu_pkg::VAL_W-1:0]    i_lane_value_6,
    input  logic [bscu_pkg::VAL_W-1:0]    i_lane_value_7,
    input  logic                          i_last_group,
    // output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bscu_pkg::VAL_W-1:0]    o_kept_value,
    output logic                          o_item_done,
    output logic                          o_batch_done
);
    import bscu_pkg::*;

    // lanes examined: LANES clamped to 1..8; higher mask bits are ignored
    localparam int EFF = f_eff_lanes(LANES);
    // queue entry: {last_group, values of examined lanes, trimmed mask}
    localparam int EW  = 1 + EFF * VAL_W + EFF;

    logic [MAX_LANES-1:0][VAL_W-1:0] lanes;
    t_q_status                       q_stat;
    logic                            push, pop;
    logic [EW-1:0]                   push_data, head;

    assign lanes = {i_lane_value_7, i_lane_value_6, i_lane_value_5, i_lane_value_4,
                    i_lane_value_3, i_lane_value_2, i_lane_value_1, i_lane_value_0};

    // Front end: takes a beat whenever the queue has room, drops empty groups.
    bscu_front #(
        .LANES (LANES),
        .EW    (EW)
    ) u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_select_mask (i_select_mask),
        .i_lanes       (lanes),
        .i_last_group  (i_last_group),
        .i_stat        (q_stat),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    // Decoupling queue: front keeps accepting while the back end drains a group, until the queue is full.
    bscu_queue #(
        .W     (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    // Back end: emits one kept value per beat; the next group loads on the
    // cycle the current one emits its last value, so groups run back to back.
    bscu_back #(
        .LANES (LANES),
        .EW    (EW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_stat       (q_stat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kept_value (o_kept_value),
        .o_item_done  (o_item_done),
        .o_batch_done (o_batch_done)
    );

endmodule
